/* src/spq_pkg.sv */
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    // Command codes carried by an input item
    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2
    } t_opcode;

    // Error codes reported with every result
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                       insert;
        logic                       remove;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctrl;

endpackage

/* src/spq_cell.sv */
// One storage cell of the sorted chain: holds one entry, trades with its neighbors.
module spq_cell
    import spq_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int COUNT_BITS = 5
) (
    input  logic                        i_clk,
    input  t_cell_ctrl                  i_ctrl,
    input  logic [COUNT_BITS-1:0]       i_count,
    input  logic                        i_left_keep,
    input  logic signed [VALUE_W-1:0]   i_left_value,
    input  logic signed [VALUE_W-1:0]   i_right_value,
    output logic                        o_keep,
    output logic signed [VALUE_W-1:0]   o_value,
    output logic signed [VALUE_W-1:0]   o_next
);

    localparam logic [COUNT_BITS-1:0] IDX = COUNT_BITS'(CELL_INDEX);

    logic signed [VALUE_W-1:0] r_value;
    logic                      w_occupied;

    // Keep the entry when it is stored and not below the new value
    assign w_occupied = (i_count > IDX);
    assign o_keep     = w_occupied && (r_value >= i_ctrl.value);

    // Select the next entry: hold, take the new value, shift right or shift left
    always_comb begin
        o_next = r_value;
        if (i_ctrl.insert) begin
            if (o_keep) begin
                o_next = r_value;
            end else if (i_left_keep) begin
                o_next = i_ctrl.value;
            end else begin
                o_next = i_left_value;
            end
        end else if (i_ctrl.remove) begin
            o_next = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= o_next;
    end

    assign o_value = r_value;

endmodule

/* src/sorted_priority_queue_unit.sv */
// Top level of the sorted priority queue: cell chain, count, rear tracking, result register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  input    | i_valid / o_stall  | i_opcode, i_value
//  output   | o_valid / i_stall  | o_front_value, o_rear_value, o_removed_value,
//           |                    | o_removed_valid, o_entry_count, o_is_empty,
//           |                    | o_error_code
//
// One item per cycle unless stalled: every cell compares its entry with the new value
// in parallel and moves in the same cycle, so the cell compare and neighbor mux set
// the timing. The result appears in the output register in the cycle after acceptance.
// Reset clears the entry count and the output valid; cell contents are not reset.
// A stalled result holds; a new item is taken only when the result register is free
// or its result is taken in the same cycle.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_opcode,
    input  logic signed [VALUE_W-1:0]   i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [VALUE_W-1:0]   o_front_value,
    output logic signed [VALUE_W-1:0]   o_rear_value,
    output logic signed [VALUE_W-1:0]   o_removed_value,
    output logic                        o_removed_valid,
    output logic [COUNT_W-1:0]          o_entry_count,
    output logic                        o_is_empty,
    output logic [1:0]                  o_error_code
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    t_cell_ctrl                w_ctrl;
    t_err                      w_err;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic signed [VALUE_W-1:0] r_rear;
    logic signed [VALUE_W-1:0] n_rear;
    logic signed [VALUE_W-1:0] w_removed;
    logic                      w_removed_ok;
    logic [CW+COUNT_W-1:0]     w_count_ext;

    logic                      w_keep  [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] w_value [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] w_next  [QUEUE_DEPTH];

    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_front;
    logic signed [VALUE_W-1:0] r_rear_out;
    logic signed [VALUE_W-1:0] r_removed;
    logic                      r_removed_ok;
    logic [COUNT_W-1:0]        r_entry_count;
    logic                      r_is_empty;
    t_err                      r_err;

    // Take an item when the result register is free or drains this cycle
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == DEPTH_C);
    assign w_empty  = (r_count == '0);

    // Decode the command for the chain
    always_comb begin
        w_ctrl.insert = 1'b0;
        w_ctrl.remove = 1'b0;
        w_ctrl.value  = i_value;
        w_err         = ERR_OK;
        case (i_opcode)
            OP_ENQUEUE: begin
                if (w_full) begin
                    w_err = ERR_FULL;
                end else begin
                    w_ctrl.insert = w_accept;
                end
            end
            OP_DEQUEUE: begin
                if (w_empty) begin
                    w_err = ERR_EMPTY;
                end else begin
                    w_ctrl.remove = w_accept;
                end
            end
            default: begin
            end
        endcase
    end

    // Build the chain of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                      w_lk;
        logic signed [VALUE_W-1:0] w_lv;
        logic signed [VALUE_W-1:0] w_rv;
        if (g == 0) begin : g_head
            assign w_lk = 1'b1;
            assign w_lv = i_value;
        end else begin : g_body
            assign w_lk = w_keep[g-1];
            assign w_lv = w_value[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_rv = w_value[g];
        end else begin : g_inner
            assign w_rv = w_value[g+1];
        end
        spq_cell #(
            .CELL_INDEX (g),
            .COUNT_BITS (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_count       (r_count),
            .i_left_keep   (w_lk),
            .i_left_value  (w_lv),
            .i_right_value (w_rv),
            .o_keep        (w_keep[g]),
            .o_value       (w_value[g]),
            .o_next        (w_next[g])
        );
    end

    // Advance the count and track the rear entry
    always_comb begin
        n_count      = r_count;
        n_rear       = r_rear;
        w_removed    = '0;
        w_removed_ok = 1'b0;
        if (w_ctrl.insert) begin
            n_count = r_count + CW'(1);
            if (w_empty || (i_value <= r_rear)) begin
                n_rear = i_value;
            end
        end else if (w_ctrl.remove) begin
            n_count      = r_count - CW'(1);
            w_removed    = w_value[0];
            w_removed_ok = 1'b1;
        end
    end

    assign w_count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rear <= n_rear;
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_front       <= (n_count == '0) ? '0 : w_next[0];
            r_rear_out    <= (n_count == '0) ? '0 : n_rear;
            r_removed     <= w_removed;
            r_removed_ok  <= w_removed_ok;
            r_entry_count <= w_count_ext[COUNT_W-1:0];
            r_is_empty    <= (n_count == '0);
            r_err         <= w_err;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_front_value   = r_front;
    assign o_rear_value    = r_rear_out;
    assign o_removed_value = r_removed;
    assign o_removed_valid = r_removed_ok;
    assign o_entry_count   = r_entry_count;
    assign o_is_empty      = r_is_empty;
    assign o_error_code    = r_err;

    // Count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above capacity");

    // A rejected enqueue leaves the count alone
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == OP_ENQUEUE) && w_full) |=> (r_count == $past(r_count)))
        else $error("full enqueue changed the count");

    // A removal is never flagged as an error
    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_removed_valid) |-> (o_error_code == ERR_OK))
        else $error("removal reported with an error");

    // An empty result shows zero front and rear
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> ((o_front_value == '0) && (o_rear_value == '0)))
        else $error("empty result with nonzero front or rear");

    // Every accepted item produces a result
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted item produced no result");

endmodule
